// File: hw/rtl/trs_pkg.sv
`default_nettype none
package trs_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 24;
    localparam int ITEM_SLOTS   = 8;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [32:0] HALF_Q30    = 33'sd536870912;
    localparam logic signed [23:0] ELEM_MAX    = 24'sh7FFFFF;
    localparam logic signed [23:0] ELEM_MIN    = 24'sh800000;

    localparam logic MAT_MODEL  = 1'b0;
    localparam logic MAT_NORMAL = 1'b1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    typedef struct packed {
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic signed [23:0] move_x;
        logic signed [23:0] move_y;
        logic signed [23:0] move_z;
    } t_in;

    typedef struct packed {
        logic               which_matrix;
        logic [1:0]         column_index;
        logic signed [23:0] elem_row0;
        logic signed [23:0] elem_row1;
        logic signed [23:0] elem_row2;
        logic               last_column;
    } t_out;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } t_lane;

    typedef struct packed {
        logic [23:0] rem;
        logic [23:0] num;
        logic [23:0] quo;
        logic [23:0] m;
        logic        ovf;
        logic        zero;
        logic        neg;
    } t_div;

    // lane 0 angle_y, lane 1 angle_x, lane 2 angle_z; div/scale/move by axis x,y,z
    typedef struct packed {
        t_lane [2:0]       lane;
        t_div  [2:0]       div;
        logic [2:0][23:0]  scale;
        logic [2:0][23:0]  move;
    } t_cell;

    // rot[k][r]: column k, row r
    typedef struct packed {
        logic [2:0][2:0][32:0] rot;
        logic [2:0][23:0]      scale;
        logic [2:0][23:0]      recip;
        logic [2:0][23:0]      move;
    } t_item;

    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + 66'sd536870912;
        return 33'(p >>> 30);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/trs_model_normal_matrix_core.sv
`default_nettype none
// Euler YXZ TRS model and normal matrix. Each transaction in gives seven result
// transactions: model columns 0..3 (rotation times scale, then translation) and
// normal columns 0..2 (rotation times reciprocal scale); last_column marks the
// seventh. The output port sends one column per cycle while i_ready is high; new
// items are taken ahead while the item queue has credit. Sine/cosine run through
// a chain of 30 CORDIC cells that also carry a 24-bit restoring divider for the
// reciprocals, then three rotation stages (quadrant fold, two product levels) and
// a small item queue (8 items) feed the column sequencer.
module trs_model_normal_matrix_core #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire trs_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output trs_pkg::t_out     o_data
);
    import trs_pkg::*;

    localparam int NW = 2 * FRAC_BITS + 26;
    localparam int CW = $clog2(ITEM_SLOTS + 1);

    logic          w_accept, w_pop;
    logic [CW-1:0] r_credit;

    t_cell               w_cd [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] w_cv;

    logic  w_rvld;
    t_item w_item;

    assign o_ready  = (r_credit < CW'(ITEM_SLOTS));
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CW'(w_accept) - CW'(w_pop);
        end
    end

    always_comb begin
        logic [2:0][15:0]        ang;
        logic [2:0][23:0]        scl;
        logic [ANGLE_BITS-1:0]   a;
        logic [31:0]             t;
        logic [31:0]             r;
        logic [23:0]             m;
        logic [NW-1:0]           num;
        logic [NW-1:0]           hi;
        ang = {i_data.angle_z, i_data.angle_x, i_data.angle_y};
        scl = {i_data.scale_z, i_data.scale_y, i_data.scale_x};
        w_cd[0].scale = scl;
        w_cd[0].move  = {i_data.move_z, i_data.move_y, i_data.move_x};
        for (int l = 0; l < 3; l++) begin
            a = ANGLE_BITS'(ang[l]);
            t = 32'(a) << (32 - ANGLE_BITS);
            r = t + 32'h2000_0000;
            w_cd[0].lane[l].quad = r[31:30];
            w_cd[0].lane[l].x    = CORDIC_GAIN;
            w_cd[0].lane[l].y    = '0;
            w_cd[0].lane[l].z    = $signed({3'b000, r[29:0]}) - HALF_Q30;
        end
        // reciprocal setup: (2^(2F) + m/2) / m, top part checked for overflow
        for (int k = 0; k < 3; k++) begin
            m   = scl[k][23] ? 24'(-scl[k]) : scl[k];
            num = (NW'(1) << (2 * FRAC_BITS)) + NW'(m >> 1);
            hi  = num >> 24;
            w_cd[0].div[k].m    = m;
            w_cd[0].div[k].neg  = scl[k][23];
            w_cd[0].div[k].zero = (scl[k] == '0);
            w_cd[0].div[k].ovf  = (hi >= NW'(m));
            w_cd[0].div[k].rem  = hi[23:0];
            w_cd[0].div[k].num  = num[23:0];
            w_cd[0].div[k].quo  = '0;
        end
    end

    assign w_cv[0] = w_accept;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_chain
        trs_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_cv[g]),
            .i_d    (w_cd[g]),
            .o_vld  (w_cv[g+1]),
            .o_d    (w_cd[g+1])
        );
    end

    trs_rot u_rot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_cv[CORDIC_STEPS]),
        .i_d    (w_cd[CORDIC_STEPS]),
        .o_vld  (w_rvld),
        .o_item (w_item)
    );

    trs_col_out u_col_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_rvld),
        .i_item (w_item),
        .o_pop  (w_pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CW'(ITEM_SLOTS))
        else $error("credit count above queue size");

    a_pop_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_credit != '0)
        else $error("queue pop without an item in flight");

    a_last_is_normal2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.last_column) |->
            (o_data.which_matrix == MAT_NORMAL && o_data.column_index == 2'd2))
        else $error("last column flag on wrong column");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/trs_cell.sv
`default_nettype none
module trs_cell #(
    parameter int STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire trs_pkg::t_cell i_d,
    output logic                o_vld,
    output trs_pkg::t_cell      o_d
);
    import trs_pkg::*;

    t_div [2:0] w_div;
    t_cell      n_d;
    logic       r_vld;
    t_cell      r_d;

    // one restoring division bit per cell for the reciprocal in the first 24 cells; later cells pass it through
    if (STEP < DIV_STEPS) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - STEP;
        always_comb begin
            logic [24:0] rs;
            rs = '0;
            for (int l = 0; l < 3; l++) begin
                w_div[l] = i_d.div[l];
                rs = {i_d.div[l].rem, i_d.div[l].num[BIT]};
                if (rs >= {1'b0, i_d.div[l].m}) begin
                    w_div[l].rem      = 24'(rs - {1'b0, i_d.div[l].m});
                    w_div[l].quo[BIT] = 1'b1;
                end else begin
                    w_div[l].rem = rs[23:0];
                end
            end
        end
    end else begin : g_pass
        assign w_div = i_d.div;
    end

    always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] at;
        n_d     = i_d;
        n_d.div = w_div;
        at = $signed({3'b000, ATAN_TURNS[STEP]});
        for (int l = 0; l < 3; l++) begin
            dx = i_d.lane[l].y >>> STEP;
            dy = i_d.lane[l].x >>> STEP;
            if (!i_d.lane[l].z[32]) begin
                n_d.lane[l].x = i_d.lane[l].x - dx;
                n_d.lane[l].y = i_d.lane[l].y + dy;
                n_d.lane[l].z = i_d.lane[l].z - at;
            end else begin
                n_d.lane[l].x = i_d.lane[l].x + dx;
                n_d.lane[l].y = i_d.lane[l].y - dy;
                n_d.lane[l].z = i_d.lane[l].z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule
`default_nettype wire

// File: hw/rtl/trs_rot.sv
`default_nettype none
module trs_rot (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire trs_pkg::t_cell i_d,
    output logic                o_vld,
    output trs_pkg::t_item      o_item
);
    import trs_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [2:0] r_vld;

    // stage a: quadrant fold and reciprocal sign and saturation
    logic signed [32:0] n_c [3];
    logic signed [32:0] n_s [3];
    logic [2:0][23:0]   n_rc;
    logic signed [32:0] r_c [3];
    logic signed [32:0] r_s [3];
    logic [2:0][23:0]   r_a_rc, r_a_sc, r_a_mv;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            case (i_d.lane[l].quad)
                QUAD_0: begin n_c[l] = i_d.lane[l].x;  n_s[l] = i_d.lane[l].y;  end
                QUAD_1: begin n_c[l] = -i_d.lane[l].y; n_s[l] = i_d.lane[l].x;  end
                QUAD_2: begin n_c[l] = -i_d.lane[l].x; n_s[l] = -i_d.lane[l].y; end
                QUAD_3: begin n_c[l] = i_d.lane[l].y;  n_s[l] = -i_d.lane[l].x; end
                default: begin n_c[l] = i_d.lane[l].x; n_s[l] = i_d.lane[l].y; end
            endcase
        end
        for (int k = 0; k < 3; k++) begin
            if (i_d.div[k].zero) begin
                n_rc[k] = ELEM_MAX;
            end else if (i_d.div[k].ovf) begin
                n_rc[k] = i_d.div[k].neg ? ELEM_MIN : ELEM_MAX;
            end else if (!i_d.div[k].neg) begin
                n_rc[k] = i_d.div[k].quo[23] ? ELEM_MAX : i_d.div[k].quo;
            end else begin
                n_rc[k] = (i_d.div[k].quo > 24'h800000) ? ELEM_MIN : 24'(-i_d.div[k].quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_s    <= n_s;
        r_a_rc <= n_rc;
        r_a_sc <= i_d.scale;
        r_a_mv <= i_d.move;
    end

    // stage b: first-level products; (c1,s1) y, (c2,s2) x, (c3,s3) z
    logic signed [32:0] r_s1s2, r_c1s2, r_c1c3, r_c2s3, r_c3s1, r_c1s3;
    logic signed [32:0] r_c2c3, r_s1s3, r_c2s1, r_c1c2, r_s2, r_s3, r_c3;
    logic [2:0][23:0]   r_b_rc, r_b_sc, r_b_mv;

    always_ff @(posedge i_clk) begin
        r_s1s2 <= qmul(r_s[0], r_s[1]);
        r_c1s2 <= qmul(r_c[0], r_s[1]);
        r_c1c3 <= qmul(r_c[0], r_c[2]);
        r_c2s3 <= qmul(r_c[1], r_s[2]);
        r_c3s1 <= qmul(r_c[2], r_s[0]);
        r_c1s3 <= qmul(r_c[0], r_s[2]);
        r_c2c3 <= qmul(r_c[1], r_c[2]);
        r_s1s3 <= qmul(r_s[0], r_s[2]);
        r_c2s1 <= qmul(r_c[1], r_s[0]);
        r_c1c2 <= qmul(r_c[0], r_c[1]);
        r_s2   <= r_s[1];
        r_s3   <= r_s[2];
        r_c3   <= r_c[2];
        r_b_rc <= r_a_rc;
        r_b_sc <= r_a_sc;
        r_b_mv <= r_a_mv;
    end

    // stage c: second-level products and sums
    t_item r_item;

    always_ff @(posedge i_clk) begin
        r_item.rot[0][0] <= r_c1c3 + qmul(r_s1s2, r_s3);
        r_item.rot[0][1] <= r_c2s3;
        r_item.rot[0][2] <= qmul(r_c1s2, r_s3) - r_c3s1;
        r_item.rot[1][0] <= qmul(r_s1s2, r_c3) - r_c1s3;
        r_item.rot[1][1] <= r_c2c3;
        r_item.rot[1][2] <= qmul(r_c1c3, r_s2) + r_s1s3;
        r_item.rot[2][0] <= r_c2s1;
        r_item.rot[2][1] <= -r_s2;
        r_item.rot[2][2] <= r_c1c2;
        r_item.recip     <= r_b_rc;
        r_item.scale     <= r_b_sc;
        r_item.move      <= r_b_mv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld  = r_vld[2];
    assign o_item = r_item;

endmodule
`default_nettype wire

// File: hw/rtl/trs_col_out.sv
`default_nettype none
module trs_col_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire trs_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output trs_pkg::t_out       o_data
);
    import trs_pkg::*;

    localparam int         PW       = $clog2(ITEM_SLOTS);
    localparam logic [2:0] COL_MOVE = 3'd3;
    localparam logic [2:0] COL_LAST = 3'd6;

    t_item         r_mem [ITEM_SLOTS];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    t_item      r_cur;
    logic       r_cur_vld;
    logic [2:0] r_col;

    logic               r_p_vld;
    logic signed [56:0] r_p_prod [3];
    logic [2:0][23:0]   r_p_mv;
    logic               r_p_move, r_p_which, r_p_last;
    logic [1:0]         r_p_idx;

    logic r_o_vld;
    t_out r_o_data;

    logic               w_adv, w_load;
    logic [1:0]         w_k;
    logic signed [23:0] w_fac;
    t_out               n_out;

    assign w_adv  = !r_o_vld || i_ready;
    assign w_load = w_adv && (!r_cur_vld || r_col == COL_LAST) && (r_cnt != '0);
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_vld) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_load) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_vld) - (PW+1)'(w_load);
        end
    end

    // column sequencer: model 0..3, normal 4..6
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_col     <= '0;
        end else if (w_load) begin
            r_cur_vld <= 1'b1;
            r_col     <= '0;
        end else if (w_adv && r_cur_vld) begin
            if (r_col == COL_LAST) begin
                r_cur_vld <= 1'b0;
            end
            r_col <= r_col + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= r_mem[r_rd];
        end
    end

    assign w_k   = (r_col[1:0] == 2'd3) ? 2'd0 : r_col[1:0];
    assign w_fac = r_col[2] ? $signed(r_cur.recip[w_k]) : $signed(r_cur.scale[w_k]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_p_prod[r] <= $signed(r_cur.rot[w_k][r]) * w_fac;
            end
            r_p_mv    <= r_cur.move;
            r_p_move  <= (r_col == COL_MOVE);
            r_p_which <= r_col[2] ? MAT_NORMAL : MAT_MODEL;
            r_p_idx   <= r_col[1:0] == 2'd3 ? 2'd3 : w_k;
            r_p_last  <= (r_col == COL_LAST);
        end
    end

    always_comb begin
        logic signed [57:0] sum;
        logic signed [57:0] sh;
        logic signed [23:0] e [3];
        for (int r = 0; r < 3; r++) begin
            sum = {r_p_prod[r][56], r_p_prod[r]} + 58'sd536870912;
            sh  = sum >>> 30;
            if (sh > 58'sd8388607) begin
                e[r] = ELEM_MAX;
            end else if (sh < -58'sd8388608) begin
                e[r] = ELEM_MIN;
            end else begin
                e[r] = sh[23:0];
            end
            if (r_p_move) begin
                e[r] = $signed(r_p_mv[r]);
            end
        end
        n_out.which_matrix = r_p_which;
        n_out.column_index = r_p_idx;
        n_out.elem_row0    = e[0];
        n_out.elem_row1    = e[1];
        n_out.elem_row2    = e[2];
        n_out.last_column  = r_p_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= r_cur_vld;
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_data <= n_out;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;

endmodule
`default_nettype wire
